>>> hw/rtl/ctrb_pkg.sv
// ctrb_pkg: word types and character codes for the CIGAR boundary parser.
// No dependencies; used by every file under hw/rtl.
`timescale 1ns / 1ps

package ctrb_pkg;

  typedef struct packed {
    logic [7:0]  cigar_char;
    logic [30:0] start_pos;
    logic        first_char;
    logic        last_char;
  } in_word_t;

  typedef struct packed {
    logic        write_valid;
    logic [5:0]  slot_index;
    logic [31:0] boundary_value;
    logic        end_of_read;
    logic [6:0]  slots_used;
    logic        overflow;
    logic        last_of_item;
  } out_word_t;

  localparam int RUN_W = 28;
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  localparam logic [7:0] CH_M     = 8'h4D;  // 'M'
  localparam logic [7:0] CH_M_LC  = 8'h6D;  // 'm'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_X     = 8'h58;  // 'X'
  localparam logic [7:0] CH_N     = 8'h4E;  // 'N'
  localparam logic [7:0] CH_D     = 8'h44;  // 'D'
  localparam logic [7:0] CH_I     = 8'h49;  // 'I'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

endpackage

>>> hw/rtl/cigar_to_reference_boundaries_core.sv
// cigar_to_reference_boundaries_core: top level of the CIGAR boundary parser.
// Depends on ctrb_pkg and ctrb_out_buf.
`timescale 1ns / 1ps
//
//   port group   dir  word          handshake
//   in_*         in   in_word_t     in_valid / in_stall
//   out_*        out  out_word_t    out_valid / out_stall
//
// One character per cycle while in_stall is low; a first character that
// is a writing op (M m = X N D) gives two words; the first holds in_stall.
// Results leave from a two-entry buffer, so input keeps flowing while one
// word waits; in_stall rises when both entries are full.
// rst clears the per-read state, the split flag and the buffer count.

module cigar_to_reference_boundaries_core #(
  parameter int MAX_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ctrb_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ctrb_pkg::out_word_t out_data
);

  localparam int NS_W  = $clog2(MAX_SLOTS + 1);
  localparam int RUN_W = ctrb_pkg::RUN_W;

  // per-read state
  logic [31:0]      prev;
  logic [NS_W-1:0]  next_slot;
  logic [RUN_W-1:0] run_len;
  logic             ins_pend;
  logic             ovf;
  logic             split;      // slot 0 word already sent for the held character

  logic [31:0]      prev_next;
  logic [NS_W-1:0]  next_slot_next;
  logic [RUN_W-1:0] run_len_next;
  logic             ins_pend_next;
  logic             ovf_next;

  // state as seen by the character (after the first-character restart)
  logic [31:0]      s_prev;
  logic [NS_W-1:0]  s_ns;
  logic [RUN_W-1:0] s_run;
  logic             s_ins;
  logic             s_ovf;

  logic [7:0]       c;
  logic             first_eff;
  logic             is_digit, is_mop, is_nd, is_ins, writes;
  logic             two_words;
  logic [31:0]      pos0;
  logic [31:0]      run_x10;
  logic [31:0]      sum;
  logic [31:0]      ext_v;
  logic [NS_W-1:0]  w_slot;
  logic             w_valid;
  logic             full;
  logic             push;

  ctrb_pkg::out_word_t res;

  assign c         = in_data.cigar_char;
  assign first_eff = in_data.first_char && !split;
  assign is_digit  = (c >= ctrb_pkg::CH_ZERO) && (c <= ctrb_pkg::CH_NINE);
  assign is_mop    = (c == ctrb_pkg::CH_M) || (c == ctrb_pkg::CH_M_LC) ||
                     (c == ctrb_pkg::CH_EQ) || (c == ctrb_pkg::CH_X);
  assign is_nd     = (c == ctrb_pkg::CH_N) || (c == ctrb_pkg::CH_D);
  assign is_ins    = (c == ctrb_pkg::CH_I);
  assign writes    = is_mop || is_nd;
  assign two_words = first_eff && writes;

  assign pos0 = (c == ctrb_pkg::CH_STAR) ? 32'd0 : {1'b0, in_data.start_pos};

  always_comb begin
    if (first_eff) begin
      s_prev = pos0;
      s_ns   = NS_W'(1);
      s_run  = '0;
      s_ins  = 1'b0;
      s_ovf  = 1'b0;
    end else begin
      s_prev = prev;
      s_ns   = next_slot;
      s_run  = run_len;
      s_ins  = ins_pend;
      s_ovf  = ovf;
    end
  end

  assign run_x10 = {1'b0, s_run, 3'b000} + {3'b000, s_run, 1'b0} + {28'd0, c[3:0] - 4'd0};
  assign sum     = s_prev + {{(32-RUN_W){1'b0}}, s_run};
  assign ext_v   = sum;

  // character effect on the state view s
  always_comb begin
    prev_next      = s_prev;
    next_slot_next = s_ns;
    run_len_next   = s_run;
    ins_pend_next  = s_ins;
    ovf_next       = s_ovf;
    w_valid        = 1'b0;
    w_slot         = '0;
    if (is_digit) begin
      // ASCII digits '0'..'9' carry their value in the low nibble
      run_len_next = (run_x10 > {{(32-RUN_W){1'b0}}, ctrb_pkg::RUN_MAX}) ?
                     ctrb_pkg::RUN_MAX : run_x10[RUN_W-1:0];
    end else begin
      run_len_next = '0;
      if (is_ins) begin
        ins_pend_next = 1'b1;
      end else if (writes) begin
        prev_next = ext_v;
        if (is_mop && s_ins) ins_pend_next = 1'b0;
        if (is_mop && s_ins && (s_ns != '0)) begin
          // extend the last slot, unless a write of this read was dropped
          w_valid = !s_ovf;
          w_slot  = s_ovf ? '0 : s_ns - NS_W'(1);
        end else if (s_ns < NS_W'(MAX_SLOTS)) begin
          w_valid        = 1'b1;
          w_slot         = s_ns;
          next_slot_next = s_ns + NS_W'(1);
        end else begin
          ovf_next = 1'b1;
        end
      end
    end
  end

  // result word for this cycle
  always_comb begin
    logic [NS_W+6:0] ns_wide;
    logic [NS_W+6:0] slot_wide;
    ns_wide   = (NS_W+7)'(next_slot_next);
    slot_wide = (NS_W+7)'(w_slot);
    if (two_words) begin
      res.write_valid    = 1'b1;
      res.slot_index     = 6'd0;
      res.boundary_value = pos0;
      res.end_of_read    = 1'b0;
      res.slots_used     = 7'd1;
      res.overflow       = 1'b0;
      res.last_of_item   = 1'b0;
    end else begin
      res.write_valid    = first_eff | w_valid;
      res.slot_index     = first_eff ? 6'd0 : slot_wide[5:0];
      res.boundary_value = first_eff ? pos0 : (w_valid ? ext_v : 32'd0);
      res.end_of_read    = in_data.last_char;
      res.slots_used     = ns_wide[6:0];
      res.overflow       = ovf_next;
      res.last_of_item   = 1'b1;
    end
  end

  assign push     = in_valid && !full;
  assign in_stall = full || (in_valid && two_words);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      next_slot <= '0;
      run_len   <= '0;
      ins_pend  <= 1'b0;
      ovf       <= 1'b0;
      split     <= 1'b0;
    end else if (push) begin
      split <= two_words;
      if (two_words) begin
        // commit only the restart; the character is handled when it is taken again
        prev      <= s_prev;
        next_slot <= s_ns;
        run_len   <= s_run;
        ins_pend  <= s_ins;
        ovf       <= s_ovf;
      end else begin
        prev      <= prev_next;
        next_slot <= next_slot_next;
        run_len   <= run_len_next;
        ins_pend  <= ins_pend_next;
        ovf       <= ovf_next;
      end
    end
  end

  ctrb_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/ctrb_out_buf.sv
// ctrb_out_buf: two-entry output buffer (result register plus skid entry).
// Depends on ctrb_pkg for the result word type.
`timescale 1ns / 1ps

module ctrb_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ctrb_pkg::out_word_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output ctrb_pkg::out_word_t out_data
);

  ctrb_pkg::out_word_t d0;
  ctrb_pkg::out_word_t d1;
  logic [1:0]          cnt;
  logic                pop;

  assign pop       = (cnt != 2'd0) && !out_stall;
  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // head leaves: second entry moves up, new word lands behind whatever remains
      if (cnt == 2'd2) begin
        d0 <= d1;
        if (push) d1 <= push_data;
      end else if (push) begin
        d0 <= push_data;
      end
    end else if (push) begin
      if (cnt == 2'd0) d0 <= push_data;
      else             d1 <= push_data;
    end
  end

endmodule

>>> dv/tb_cigar_to_reference_boundaries_core.sv
// tb_cigar_to_reference_boundaries_core: self-checking bench for the CIGAR boundary parser.
// Streams directed and random CIGAR characters and scores every output word against
// a cycle-free model of the boundary list. Depends on ctrb_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_cigar_to_reference_boundaries_core;

  localparam int SLOT_CAP = 64;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  localparam logic [7:0] CH_S = 8'h53;  // 'S'
  localparam logic [7:0] CH_H = 8'h48;  // 'H'
  localparam logic [7:0] CH_P = 8'h50;  // 'P'

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ctrb_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ctrb_pkg::out_word_t out_data;

  cigar_to_reference_boundaries_core #(.MAX_SLOTS(SLOT_CAP)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ctrb_pkg::in_word_t  char_q[$];      // characters waiting to be offered
  ctrb_pkg::out_word_t boundary_q[$];  // predicted output words, oldest first
  ctrb_pkg::out_word_t step_words[$];  // words of the character being predicted
  logic [7:0]          op_set[10];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int n_errors = 0;
  int read_chars = 0;

  // boundary list state
  logic [31:0] cur_coord = '0;
  int          filled_slots = 0;
  logic [27:0] run_len = '0;
  bit          ins_pend = 1'b0;
  bit          ovf_flag = 1'b0;

  function automatic ctrb_pkg::out_word_t make_word(bit wr, logic [5:0] slot,
                                                    logic [31:0] val);
    ctrb_pkg::out_word_t w;
    w = '0;
    w.write_valid = wr;
    w.slot_index = slot;
    w.boundary_value = val;
    w.slots_used = 7'(filled_slots);
    w.overflow = ovf_flag;
    return w;
  endfunction

  task automatic append_boundary(input logic [31:0] val);
    cur_coord = val;
    if (filled_slots < SLOT_CAP) begin
      filled_slots++;
      step_words.push_back(make_word(1'b1, 6'(filled_slots - 1), val));
    end else begin
      ovf_flag = 1'b1;
      step_words.push_back(make_word(1'b0, '0, '0));
    end
  endtask

  // I followed by a match op widens the last written slot instead of adding one
  task automatic extend_boundary(input logic [31:0] val);
    if (filled_slots == 0) begin
      append_boundary(val);
    end else begin
      cur_coord = val;
      if (ovf_flag) step_words.push_back(make_word(1'b0, '0, '0));
      else step_words.push_back(make_word(1'b1, 6'(filled_slots - 1), val));
    end
  endtask

  task automatic predict_boundaries(input ctrb_pkg::in_word_t w);
    logic [31:0]         acc;
    logic [31:0]         sum;
    ctrb_pkg::out_word_t tail;
    step_words = {};
    if (w.first_char) begin
      cur_coord = '0;
      filled_slots = 0;
      run_len = '0;
      ins_pend = 1'b0;
      ovf_flag = 1'b0;
      append_boundary((w.cigar_char == ctrb_pkg::CH_STAR) ? 32'd0 : {1'b0, w.start_pos});
    end
    if (w.cigar_char >= ctrb_pkg::CH_ZERO && w.cigar_char <= ctrb_pkg::CH_NINE) begin
      acc = 32'(run_len) * 32'd10 + 32'(w.cigar_char - ctrb_pkg::CH_ZERO);
      run_len = (acc > 32'(ctrb_pkg::RUN_MAX)) ? ctrb_pkg::RUN_MAX : acc[27:0];
    end else begin
      sum = cur_coord + 32'(run_len);
      run_len = '0;
      case (w.cigar_char)
        ctrb_pkg::CH_M, ctrb_pkg::CH_M_LC, ctrb_pkg::CH_EQ, ctrb_pkg::CH_X: begin
          if (ins_pend) begin
            ins_pend = 1'b0;
            extend_boundary(sum);
          end else begin
            append_boundary(sum);
          end
        end
        ctrb_pkg::CH_N, ctrb_pkg::CH_D: append_boundary(sum);
        ctrb_pkg::CH_I: ins_pend = 1'b1;
        default: ;
      endcase
    end
    if (step_words.size() == 0) step_words.push_back(make_word(1'b0, '0, '0));
    tail = step_words.pop_back();
    tail.last_of_item = 1'b1;
    tail.end_of_read = w.last_char;
    step_words.push_back(tail);
    foreach (step_words[i]) boundary_q.push_back(step_words[i]);
  endtask

  // driver: offers queued characters
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (!in_valid || !in_stall) begin
        if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served < hold_asks) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      n_errors++;
    end
  endtask

  // monitor: an accepted character is predicted before the word of this edge is
  // scored, since a slot 0 word can leave at the edge that accepts its character
  always @(posedge clk) begin : mon
    ctrb_pkg::out_word_t want;
    if (!rst && in_valid && !in_stall) predict_boundaries(in_data);
    if (!rst && out_valid && !out_stall) begin
      if (boundary_q.size() == 0) begin
        $error("output word with nothing expected: 0x%0h", out_data);
        n_errors++;
      end else begin
        want = boundary_q.pop_front();
        cmp_field("write_valid", 32'(want.write_valid), 32'(out_data.write_valid));
        cmp_field("slot_index", 32'(want.slot_index), 32'(out_data.slot_index));
        cmp_field("boundary_value", want.boundary_value, out_data.boundary_value);
        cmp_field("end_of_read", 32'(want.end_of_read), 32'(out_data.end_of_read));
        cmp_field("slots_used", 32'(want.slots_used), 32'(out_data.slots_used));
        cmp_field("overflow", 32'(want.overflow), 32'(out_data.overflow));
        cmp_field("last_of_item", 32'(want.last_of_item), 32'(out_data.last_of_item));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_char(input logic [7:0] c, input logic [30:0] pos, input bit first,
                           input bit last);
    ctrb_pkg::in_word_t w;
    w.cigar_char = c;
    w.start_pos = pos;
    w.first_char = first;
    w.last_char = last;
    char_q.push_back(w);
  endtask

  task automatic push_text(input string s, input logic [30:0] pos, input bit first,
                           input bit last);
    int k;
    for (k = 0; k < s.len(); k++)
      push_char(s[k], (k == 0) ? pos : 31'($urandom()), first && k == 0,
                last && k == s.len() - 1);
  endtask

  // dense reads favor writing ops with short runs, enough to run out of slots
  task automatic add_read(input int n_ops, input bit dense, input bit no_first,
                          input bit no_last);
    logic [7:0]  txt[$];
    logic [30:0] pos;
    int          k, r, ndig;
    txt = {};
    if (!dense && $urandom_range(15) == 0) begin
      txt.push_back(ctrb_pkg::CH_STAR);
    end else begin
      for (k = 0; k < n_ops; k++) begin
        r = $urandom_range(99);
        if (dense) ndig = $urandom_range(1);
        else if (r < 5) ndig = 0;
        else if (r < 15) ndig = $urandom_range(10, 4);
        else ndig = $urandom_range(3, 1);
        repeat (ndig) txt.push_back(ctrb_pkg::CH_ZERO + 8'($urandom_range(9)));
        if (dense && $urandom_range(3) != 0) txt.push_back(op_set[$urandom_range(5)]);
        else txt.push_back(op_set[$urandom_range(9)]);
      end
    end
    case ($urandom_range(7))
      0: pos = '0;
      1: pos = '1;
      2: pos = {15'h7FFF, 16'($urandom())};
      default: pos = 31'($urandom());
    endcase
    for (k = 0; k < txt.size(); k++)
      push_char(txt[k], (k == 0) ? pos : 31'($urandom()), k == 0 && !no_first,
                k == txt.size() - 1 && !no_last);
    read_chars += txt.size();
  endtask

  task automatic fill_random(input int n_items);
    int stop_at, r;
    stop_at = read_chars + n_items;
    while (read_chars < stop_at) begin
      r = $urandom_range(99);
      if (r < 6)
        repeat ($urandom_range(4, 1))
          push_char(8'($urandom_range(255)), 31'($urandom()), $urandom_range(3) == 0,
                    $urandom_range(3) == 0);
      else if (r < 10) add_read($urandom_range(110, 80), 1'b1, 1'b0, 1'b0);
      else if (r < 18) add_read($urandom_range(8, 1), 1'b0, r < 14, r >= 14);
      else add_read($urandom_range(8, 1), 1'b0, 1'b0, 1'b0);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (char_q.size() != 0 || in_valid || boundary_q.size() != 0);
  endtask

  initial begin
    op_set = '{ctrb_pkg::CH_M, ctrb_pkg::CH_M_LC, ctrb_pkg::CH_EQ, ctrb_pkg::CH_X,
               ctrb_pkg::CH_N, ctrb_pkg::CH_D, ctrb_pkg::CH_I, CH_S, CH_H, CH_P};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: ops before any read start, lone '*', every writing op, saturated run
    push_text("IM", 31'($urandom()), 1'b0, 1'b0);
    push_text("*", 31'h7FFF_FFFF, 1'b1, 1'b1);
    push_text("M2I3M1D4=5XmNH", 31'h7FFF_FFFF, 1'b1, 1'b1);
    push_text("999999999N", '0, 1'b1, 1'b1);
    wait_drained();

    // receiver holds off while the sender keeps pushing
    add_read(100, 1'b1, 1'b0, 1'b0);
    fill_random(250);
    hold_asks = hold_asks + 1;
    wait_drained();

    send_idle_pct = 51;
    fill_random(290);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 51;
    fill_random(290);
    wait_drained();

    send_idle_pct = 19;
    stall_pct = 19;
    fill_random(290);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 0;
    fill_random(250);
    wait_drained();

    repeat (20) @(negedge clk);
    if (n_errors == 0 && boundary_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
